[rtl/core/ict_pkg.sv]
// ============================================================================
// ict_pkg - shared types and constants of the inline command tokenizer
// Character codes, parse modes, status codes and the structs that pass
// between the tokenizer step logic and the top level.
// ============================================================================
package ict_pkg;

    localparam int MAX_ARGS_DEF = 255;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_AFTER_TEXT = 2'd1,
        ST_UNTERM     = 2'd2,
        ST_TOO_MANY   = 2'd3
    } ict_status_t;

    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_UNQ  = 6'b000010,
        MODE_DQ   = 6'b000100,
        MODE_SQ   = 6'b001000,
        MODE_AFTQ = 6'b010000,
        MODE_ERR  = 6'b100000
    } ict_mode_t;

    typedef struct packed {
        ict_mode_t   mode;
        logic        esc;
        logic [7:0]  arg_cnt;
        ict_status_t err;
    } ict_state_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic        byte_valid;
        logic [7:0]  arg_index;
        logic        arg_end;
        logic        line_done;
        logic [7:0]  arg_total;
        ict_status_t status;
    } ict_result_t;

    localparam ict_state_t STATE_RESET = '{mode: MODE_IDLE, esc: 1'b0,
                                           arg_cnt: 8'd0, err: ST_OK};

endpackage

[rtl/core/ict_step.sv]
// ============================================================================
// ict_step - per-byte tokenizer update
// Combinational next state and result for one byte of a command line.
// ============================================================================
module ict_step #(
    parameter int MAX_ARGS = ict_pkg::MAX_ARGS_DEF
) (
    input  ict_pkg::ict_state_t  cur,
    input  logic [7:0]           byte_in,
    input  logic                 last,
    output ict_pkg::ict_state_t  nxt,
    output ict_pkg::ict_result_t res
);

    localparam logic [7:0] MAX_CNT = 8'(MAX_ARGS);

    always_comb
    begin
        ict_pkg::ict_state_t ns;
        logic                eol;
        logic                ws;
        logic                valid;
        logic                aend;
        logic [7:0]          qch;

        ns    = cur;
        eol   = (byte_in == ict_pkg::CH_NUL) || last;
        ws    = byte_in inside {ict_pkg::CH_SPACE, ict_pkg::CH_TAB, ict_pkg::CH_LF,
                                ict_pkg::CH_VT, ict_pkg::CH_FF, ict_pkg::CH_CR};
        valid = 1'b0;
        aend  = 1'b0;
        qch   = (cur.mode == ict_pkg::MODE_DQ) ? ict_pkg::CH_DQUOTE : ict_pkg::CH_SQUOTE;

        case (cur.mode)
            ict_pkg::MODE_IDLE:
            begin
                if (byte_in == ict_pkg::CH_NUL || ws)
                begin
                    ns = cur;
                end
                else if (cur.arg_cnt >= MAX_CNT)
                begin
                    ns.err  = ict_pkg::ST_TOO_MANY;
                    ns.mode = ict_pkg::MODE_ERR;
                    ns.esc  = 1'b0;
                end
                else if (byte_in == ict_pkg::CH_DQUOTE)
                begin
                    ns.mode = ict_pkg::MODE_DQ;
                    ns.esc  = 1'b0;
                end
                else if (byte_in == ict_pkg::CH_SQUOTE)
                begin
                    ns.mode = ict_pkg::MODE_SQ;
                    ns.esc  = 1'b0;
                end
                else
                begin
                    ns.mode = ict_pkg::MODE_UNQ;
                    valid   = 1'b1;
                end
            end
            ict_pkg::MODE_UNQ:
            begin
                if (byte_in inside {ict_pkg::CH_NUL, ict_pkg::CH_SPACE, ict_pkg::CH_TAB,
                                    ict_pkg::CH_CR, ict_pkg::CH_LF})
                begin
                    aend       = 1'b1;
                    ns.arg_cnt = cur.arg_cnt + 8'd1;
                    ns.mode    = ict_pkg::MODE_IDLE;
                end
                else if (byte_in == ict_pkg::CH_DQUOTE)
                begin
                    ns.mode = ict_pkg::MODE_DQ;
                    ns.esc  = 1'b0;
                end
                else if (byte_in == ict_pkg::CH_SQUOTE)
                begin
                    ns.mode = ict_pkg::MODE_SQ;
                    ns.esc  = 1'b0;
                end
                else
                begin
                    valid = 1'b1;
                end
            end
            ict_pkg::MODE_DQ, ict_pkg::MODE_SQ:
            begin
                if (byte_in == ict_pkg::CH_NUL)
                begin
                    valid = 1'b0;
                end
                else if (byte_in == ict_pkg::CH_BSLASH)
                begin
                    ns.esc = ~cur.esc;
                    valid  = 1'b1;
                end
                else if (byte_in == qch && !cur.esc)
                begin
                    ns.mode = ict_pkg::MODE_AFTQ;
                end
                else
                begin
                    ns.esc = 1'b0;
                    valid  = 1'b1;
                end
            end
            ict_pkg::MODE_AFTQ:
            begin
                if (byte_in == ict_pkg::CH_NUL || ws)
                begin
                    aend       = 1'b1;
                    ns.arg_cnt = cur.arg_cnt + 8'd1;
                    ns.mode    = ict_pkg::MODE_IDLE;
                end
                else
                begin
                    ns.err  = ict_pkg::ST_AFTER_TEXT;
                    ns.mode = ict_pkg::MODE_ERR;
                    ns.esc  = 1'b0;
                end
            end
            default:
            begin
                ns = cur;
            end
        endcase

        // close an open argument or flag an open quote at end of line
        if (eol)
        begin
            if (ns.mode == ict_pkg::MODE_UNQ || ns.mode == ict_pkg::MODE_AFTQ)
            begin
                aend       = 1'b1;
                ns.arg_cnt = ns.arg_cnt + 8'd1;
            end
            else if (ns.mode == ict_pkg::MODE_DQ || ns.mode == ict_pkg::MODE_SQ)
            begin
                ns.err  = ict_pkg::ST_UNTERM;
                ns.mode = ict_pkg::MODE_ERR;
                ns.esc  = 1'b0;
            end
        end

        res.byte_out   = byte_in;
        res.byte_valid = valid;
        res.arg_index  = cur.arg_cnt;
        res.arg_end    = aend;
        res.line_done  = eol;
        res.arg_total  = ns.arg_cnt;
        res.status     = ns.err;

        nxt = eol ? ict_pkg::STATE_RESET : ns;
    end

endmodule

[rtl/core/inline_command_tokenizer.sv]
// ============================================================================
// inline_command_tokenizer - splits a command line into arguments
// Byte-wide stream in, one annotated word out for every byte taken.
// ============================================================================
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata/s_tlast) carries one byte of
//   the line per word; s_tlast marks the final byte, and a zero byte also ends
//   the line. The master channel returns exactly one word per input word, in
//   order: the byte, whether it is argument text, the argument index, an
//   end-of-argument mark, the completed-argument count and a status in tuser.
//   m_tlast marks the word that ends the line; parse state then returns to
//   idle with a zero argument count and status OK.
//   The byte lands in the input register on the accepting edge, and the step
//   logic fills the result register from it once that register is free.
//   Throughput is one byte per cycle while the receiver keeps up; the only
//   loop is the parse state register, updated by the combinational step logic.
//   When the receiver stalls, the result register holds its word; an empty
//   input register still takes one more byte, and once both registers hold
//   words s_tready drops in the same cycle as m_tready, so no word is lost.
//   Reset (rst_n low) empties both registers and clears parse state.
// ============================================================================
module inline_command_tokenizer #(
    parameter int MAX_ARGS = ict_pkg::MAX_ARGS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] byte_out, [8] byte_valid, [16:9] arg_index,
                                   // [17] arg_end, [25:18] arg_total, [31:26] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // line_done
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    ict_pkg::ict_state_t  state_reg;
    ict_pkg::ict_state_t  state_next;
    logic                 out_valid_reg;
    ict_pkg::ict_result_t out_reg;
    ict_pkg::ict_result_t out_next;
    logic                 advance;

    // the result register frees up when empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    ict_step #(
        .MAX_ARGS (MAX_ARGS)
    ) u_step (
        .cur     (state_reg),
        .byte_in (in_byte_reg),
        .last    (in_last_reg),
        .nxt     (state_next),
        .res     (out_next)
    );

    // input register: take a byte whenever the slot is free or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // advance parse state only when the byte moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ict_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.arg_total, out_reg.arg_end, out_reg.arg_index,
                       out_reg.byte_valid, out_reg.byte_out};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.line_done;

endmodule

[rtl/core/ict_checker.sv]
// ============================================================================
// ict_checker - port-level checks of the inline command tokenizer
// Watches the master channel for stall behavior, count consistency and
// argument ends under an error status.
module ict_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // hold a stalled word
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output word changed while stalled");

    // the total advances by one exactly when an argument closes
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[25:18] == 8'(m_tdata[16:9] + {7'd0, m_tdata[17]}))
        else $error("arg_total does not match arg_index and arg_end");

    // an erroring word never closes an argument
    a_err_no_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ict_pkg::ST_OK |-> !m_tdata[17])
        else $error("argument closed under an error status");

endmodule

bind inline_command_tokenizer ict_checker u_ict_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
